FILE: rtl/ncbl_pkg.sv
// ----------------------------------------------------------------------------
// ncbl_pkg
// shared types, character codes and helpers for the checksum / baud lock unit
// ----------------------------------------------------------------------------
package ncbl_pkg;

  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharBang   = 8'h21;
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharLf     = 8'h0A;
  localparam logic [7:0] CharCr     = 8'h0D;

  localparam int unsigned MinCheckLen     = 4;
  localparam int unsigned MinPlausibleLen = 6;

  // configuration register indexes
  typedef enum logic [1:0] {
    CfgWindowTicks    = 2'd0,
    CfgLockThreshold  = 2'd1,
    CfgSilenceTicks   = 2'd2,
    CfgCandidateCount = 2'd3
  } cfg_index_e;

  // status of the line that the current word ends
  typedef struct packed {
    logic line_end;
    logic checksum_ok;
    logic plausible;
  } line_status_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    r.valid = 1'b1;
    r.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.value = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.value = 4'(c - 8'h61 + 8'd10);
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

  function automatic logic is_start_char(input logic [7:0] c);
    return (c == CharDollar) || (c == CharBang);
  endfunction

endpackage

FILE: rtl/nmea_checksum_baud_lock_unit.sv
// ----------------------------------------------------------------------------
// nmea_checksum_baud_lock_unit
// line checksum validation and baud-rate scan / lock control
// ----------------------------------------------------------------------------
// path: an accepted word passes the input register, then the result register
// throughput: one word per cycle unless out_ready_i stalls the two-stage pipe;
//   while a result waits, a new word is taken only into an empty input register
// reset: asynchronous active low; scanning at candidate 0, counters and line
//   state cleared, configuration back to its default values
module nmea_checksum_baud_lock_unit #(
  parameter int unsigned LINE_CAPACITY = 95
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  byte_value_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        line_end_o,
  output logic        checksum_ok_o,
  output logic        plausible_o,
  output logic        locked_o,
  output logic [2:0]  candidate_index_o,
  output logic        retune_o
);

  localparam int unsigned LenW = $clog2(LINE_CAPACITY + 1);

  // configuration registers
  logic [15:0] window_ticks_q;
  logic [3:0]  lock_threshold_q;
  logic [15:0] silence_ticks_q;
  logic [3:0]  candidate_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_ticks_q    <= 16'd1000;
      lock_threshold_q  <= 4'd2;
      silence_ticks_q   <= 16'd10000;
      candidate_count_q <= 4'd6;
    end else if (cfg_we_i) begin
      unique case (ncbl_pkg::cfg_index_e'(cfg_index_i))
        ncbl_pkg::CfgWindowTicks:    window_ticks_q    <= cfg_data_i;
        ncbl_pkg::CfgLockThreshold:  lock_threshold_q  <= cfg_data_i[3:0];
        ncbl_pkg::CfgSilenceTicks:   silence_ticks_q   <= cfg_data_i;
        ncbl_pkg::CfgCandidateCount: candidate_count_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // input register stage
  logic       s1_valid_q;
  logic       s1_mode_q;
  logic [7:0] s1_byte_q;
  logic       s1_fire;   // stage 1 word moves into the result register

  assign s1_fire    = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_mode_q <= mode_i;
      s1_byte_q <= byte_value_i;
    end
  end

  // processing: line checks feed the lock controller, a restart clears the line
  ncbl_pkg::line_status_t status;
  logic                   restart;
  logic                   locked_nx;
  logic [2:0]             cand_nx;

  ncbl_line_check #(
    .LineCapacity (LINE_CAPACITY),
    .LenW         (LenW)
  ) u_line (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (s1_fire),
    .mode_i       (s1_mode_q),
    .byte_value_i (s1_byte_q),
    .clear_i      (restart),
    .status_o     (status)
  );

  ncbl_lock_ctrl u_lock (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .fire_i            (s1_fire),
    .mode_i            (s1_mode_q),
    .status_i          (status),
    .window_ticks_i    (window_ticks_q),
    .lock_threshold_i  (lock_threshold_q),
    .silence_ticks_i   (silence_ticks_q),
    .candidate_count_i (candidate_count_q),
    .restart_o         (restart),
    .locked_o          (locked_nx),
    .candidate_index_o (cand_nx)
  );

  // result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      line_end_o        <= status.line_end;
      checksum_ok_o     <= status.checksum_ok;
      plausible_o       <= status.plausible;
      locked_o          <= locked_nx;
      candidate_index_o <= cand_nx;
      retune_o          <= restart;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/ncbl_line_check.sv
// ----------------------------------------------------------------------------
// ncbl_line_check
// line assembly state and checksum / plausibility checks on line end
// ----------------------------------------------------------------------------
module ncbl_line_check #(
  parameter int unsigned LineCapacity = 95,
  parameter int unsigned LenW         = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic                  mode_i,
  input  logic [7:0]            byte_value_i,
  input  logic                  clear_i,
  output ncbl_pkg::line_status_t status_o
);

  logic [LenW-1:0] len_q, len_d;
  logic [7:0]      xor_q, xor_d;
  logic [7:0]      first_q, first_d;
  logic [23:0]     tail_q, tail_d;

  ncbl_pkg::hex_digit_t hi, lo;
  logic                 is_lf, is_cr;
  logic [7:0]           body;

  assign hi    = ncbl_pkg::hex_decode(tail_q[15:8]);
  assign lo    = ncbl_pkg::hex_decode(tail_q[7:0]);
  assign is_lf = !mode_i && (byte_value_i == ncbl_pkg::CharLf);
  assign is_cr = !mode_i && (byte_value_i == ncbl_pkg::CharCr);
  assign body  = xor_q ^ tail_q[23:16] ^ tail_q[15:8] ^ tail_q[7:0];

  always_comb begin
    status_o.line_end    = is_lf;
    status_o.checksum_ok = is_lf
                           && (len_q >= LenW'(ncbl_pkg::MinCheckLen))
                           && ncbl_pkg::is_start_char(first_q)
                           && (tail_q[23:16] == ncbl_pkg::CharStar)
                           && hi.valid && lo.valid
                           && (body == {hi.value, lo.value});
    status_o.plausible   = is_lf
                           && (len_q >= LenW'(ncbl_pkg::MinPlausibleLen))
                           && ncbl_pkg::is_start_char(first_q);
  end

  always_comb begin
    len_d   = len_q;
    xor_d   = xor_q;
    first_d = first_q;
    tail_d  = tail_q;
    if (mode_i) begin
      if (clear_i) begin
        len_d = '0;
      end
    end else if (is_lf) begin
      len_d = '0;
    end else if (!is_cr && (len_q < LenW'(LineCapacity))) begin
      if (len_q == '0) begin
        first_d = byte_value_i;
        xor_d   = 8'd0;
      end else begin
        xor_d = xor_q ^ byte_value_i;
      end
      tail_d = {tail_q[15:0], byte_value_i};
      len_d  = len_q + LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      xor_q   <= 8'd0;
      first_q <= 8'd0;
      tail_q  <= 24'd0;
    end else if (fire_i) begin
      len_q   <= len_d;
      xor_q   <= xor_d;
      first_q <= first_d;
      tail_q  <= tail_d;
    end
  end

endmodule

FILE: rtl/ncbl_lock_ctrl.sv
// ----------------------------------------------------------------------------
// ncbl_lock_ctrl
// candidate scan, lock decision and silence watchdog
// ----------------------------------------------------------------------------
module ncbl_lock_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  logic                   mode_i,
  input  ncbl_pkg::line_status_t status_i,
  input  logic [15:0]            window_ticks_i,
  input  logic [3:0]             lock_threshold_i,
  input  logic [15:0]            silence_ticks_i,
  input  logic [3:0]             candidate_count_i,
  output logic                   restart_o,
  output logic                   locked_o,
  output logic [2:0]             candidate_index_o
);

  logic        locked_q, locked_d;
  logic [2:0]  cand_q, cand_d;
  logic [15:0] win_q, win_d;
  logic [3:0]  valid_q, valid_d;
  logic [15:0] sil_q, sil_d;

  logic [3:0]  cnt_eff;
  logic [3:0]  next_idx;
  logic [15:0] win_inc, sil_inc;
  logic [3:0]  valid_inc;

  always_comb begin
    if (candidate_count_i == 4'd0) begin
      cnt_eff = 4'd1;
    end else if (candidate_count_i > 4'd8) begin
      cnt_eff = 4'd8;
    end else begin
      cnt_eff = candidate_count_i;
    end
    next_idx  = {1'b0, cand_q} + 4'd1;
    win_inc   = (win_q == 16'hFFFF) ? win_q : win_q + 16'd1;
    sil_inc   = (sil_q == 16'hFFFF) ? sil_q : sil_q + 16'd1;
    valid_inc = (status_i.checksum_ok && valid_q != 4'hF) ? valid_q + 4'd1 : valid_q;
  end

  always_comb begin
    locked_d  = locked_q;
    cand_d    = cand_q;
    win_d     = win_q;
    valid_d   = valid_q;
    sil_d     = sil_q;
    restart_o = 1'b0;
    if (mode_i) begin
      if (!locked_q) begin
        win_d = win_inc;
        if (win_inc >= window_ticks_i) begin
          cand_d    = (next_idx >= cnt_eff) ? 3'd0 : next_idx[2:0];
          valid_d   = 4'd0;
          win_d     = 16'd0;
          restart_o = 1'b1;
        end
      end else begin
        sil_d = sil_inc;
        if (sil_inc >= silence_ticks_i) begin
          locked_d  = 1'b0;
          cand_d    = 3'd0;
          valid_d   = 4'd0;
          win_d     = 16'd0;
          restart_o = 1'b1;
        end
      end
    end else if (status_i.line_end) begin
      if (!locked_q) begin
        valid_d = valid_inc;
        if (valid_inc >= lock_threshold_i) begin
          locked_d = 1'b1;
          sil_d    = 16'd0;
        end
      end else if (status_i.plausible) begin
        sil_d = 16'd0;
      end
    end
  end

  assign locked_o          = locked_d;
  assign candidate_index_o = cand_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locked_q <= 1'b0;
      cand_q   <= 3'd0;
      win_q    <= 16'd0;
      valid_q  <= 4'd0;
      sil_q    <= 16'd0;
    end else if (fire_i) begin
      locked_q <= locked_d;
      cand_q   <= cand_d;
      win_q    <= win_d;
      valid_q  <= valid_d;
      sil_q    <= sil_d;
    end
  end

endmodule
